### design/rrts_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin thread scheduler package
// Shared sizes, codes, table port structs and the microcode ROM.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned KEY_BITS  = 32;
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
  localparam int unsigned UPC_W     = 5;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [UPC_W-1:0]    upc_t;

  typedef enum logic [1:0] {
    SS_FREE  = 2'd0,
    SS_SLEEP = 2'd1,
    SS_READY = 2'd2,
    SS_RUN   = 2'd3
  } slot_st_e;

  // Command codes.
  localparam logic [2:0] CMD_START    = 3'd0;
  localparam logic [2:0] CMD_SLEEP    = 3'd1;
  localparam logic [2:0] CMD_WAKEUP   = 3'd2;
  localparam logic [2:0] CMD_SCHEDULE = 3'd3;
  localparam logic [2:0] CMD_END      = 3'd4;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOFREE  = 2'd1;
  localparam logic [1:0] STAT_NORUN   = 2'd2;
  localparam logic [1:0] STAT_REFUSED = 2'd3;

  localparam logic [3:0] WOKEN_MAX = 4'hF;

  // Table read address source.
  typedef enum logic [1:0] {
    RS_CUR,
    RS_NEXT,
    RS_CURNEXT
  } rsel_e;

  // Walk pointer update.
  typedef enum logic [1:0] {
    NM_HOLD,
    NM_FIRST,
    NM_STEP
  } node_mode_e;

  // Datapath operation of one step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LATCH,
    OP_FIND,
    OP_START_A,
    OP_START_B,
    OP_SLEEP,
    OP_WAKE,
    OP_SCAN,
    OP_FAIL,
    OP_DEMOTE,
    OP_PROMOTE,
    OP_UNLINK,
    OP_REFUSE,
    OP_NOFREE,
    OP_RESULT
  } op_e;

  // Sequencing: J_IF takes the target on the condition, J_WAIT holds on it,
  // J_LOOP takes the target on it, else repeats while the walk goes on.
  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_IF,
    J_WAIT,
    J_LOOP,
    J_DISP
  } jmp_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_IN,
    C_NOT_LIVE,
    C_NO_FREE,
    C_NOT_RUN,
    C_END_BAD,
    C_HIT,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic       accept;
    rsel_e      rsel;
    node_mode_e node;
    op_e        op;
    jmp_e       jmp;
    cond_e      cond;
    upc_t       tgt;
  } ucw_t;

  // Microprogram addresses.
  localparam upc_t U_IDLE   = 5'd0;
  localparam upc_t U_DISP   = 5'd1;
  localparam upc_t U_START  = 5'd2;
  localparam upc_t U_FIND   = 5'd3;
  localparam upc_t U_STA    = 5'd4;
  localparam upc_t U_STB    = 5'd5;
  localparam upc_t U_SLEEP  = 5'd6;
  localparam upc_t U_SLW    = 5'd7;
  localparam upc_t U_WAKE   = 5'd8;
  localparam upc_t U_WDONE  = 5'd9;
  localparam upc_t U_SCH    = 5'd10;
  localparam upc_t U_SFAIL  = 5'd11;
  localparam upc_t U_DEM    = 5'd12;
  localparam upc_t U_PROM   = 5'd13;
  localparam upc_t U_END    = 5'd14;
  localparam upc_t U_ENDU   = 5'd15;
  localparam upc_t U_REFUSE = 5'd16;
  localparam upc_t U_NOFREE = 5'd17;
  localparam upc_t U_FIN    = 5'd18;
  localparam upc_t U_RES    = 5'd19;

  typedef struct packed {
    slot_t    raddr;
    logic     st_we;
    slot_t    st_wa;
    slot_st_e st_wd;
    logic     key_we;
    slot_t    key_wa;
    key_t     key_wd;
    logic     nx_we;
    slot_t    nx_wa;
    slot_t    nx_wd;
    logic     pv_we;
    slot_t    pv_wa;
    slot_t    pv_wd;
  } tbl_req_t;

  typedef struct packed {
    slot_st_e st;
    key_t     key;
    slot_t    nx;
    slot_t    pv;
    logic     any_free;
    slot_t    first_free;
  } tbl_rsp_t;

  function automatic ucw_t uw(input logic accept, input rsel_e rsel,
                              input node_mode_e node, input op_e op,
                              input jmp_e jmp, input cond_e cond, input upc_t tgt);
    ucw_t w;
    w.accept = accept;
    w.rsel   = rsel;
    w.node   = node;
    w.op     = op;
    w.jmp    = jmp;
    w.cond   = cond;
    w.tgt    = tgt;
    return w;
  endfunction

  function automatic ucw_t ucode_rom(input upc_t pc);
    ucw_t w;
    unique case (pc)
      U_IDLE:   w = uw(1'b1, RS_CUR, NM_HOLD, OP_ACCEPT, J_WAIT, C_NO_IN, U_DISP);
      U_DISP:   w = uw(1'b0, RS_NEXT, NM_FIRST, OP_LATCH, J_DISP, C_NEVER, U_IDLE);
      U_START:  w = uw(1'b0, RS_CUR, NM_HOLD, OP_NONE, J_IF, C_NOT_LIVE, U_REFUSE);
      U_FIND:   w = uw(1'b0, RS_CUR, NM_HOLD, OP_FIND, J_IF, C_NO_FREE, U_NOFREE);
      U_STA:    w = uw(1'b0, RS_CUR, NM_HOLD, OP_START_A, J_NEXT, C_NEVER, U_IDLE);
      U_STB:    w = uw(1'b0, RS_CUR, NM_HOLD, OP_START_B, J_GOTO, C_NEVER, U_FIN);
      U_SLEEP:  w = uw(1'b0, RS_CUR, NM_HOLD, OP_NONE, J_IF, C_NOT_RUN, U_REFUSE);
      U_SLW:    w = uw(1'b0, RS_CUR, NM_HOLD, OP_SLEEP, J_GOTO, C_NEVER, U_FIN);
      U_WAKE:   w = uw(1'b0, RS_NEXT, NM_STEP, OP_WAKE, J_LOOP, C_NEVER, U_WAKE);
      U_WDONE:  w = uw(1'b0, RS_CUR, NM_HOLD, OP_NONE, J_GOTO, C_NEVER, U_FIN);
      U_SCH:    w = uw(1'b0, RS_NEXT, NM_STEP, OP_SCAN, J_LOOP, C_HIT, U_DEM);
      U_SFAIL:  w = uw(1'b0, RS_CUR, NM_HOLD, OP_FAIL, J_GOTO, C_NEVER, U_FIN);
      U_DEM:    w = uw(1'b0, RS_CUR, NM_HOLD, OP_DEMOTE, J_NEXT, C_NEVER, U_IDLE);
      U_PROM:   w = uw(1'b0, RS_CUR, NM_HOLD, OP_PROMOTE, J_GOTO, C_NEVER, U_FIN);
      U_END:    w = uw(1'b0, RS_CUR, NM_HOLD, OP_NONE, J_IF, C_END_BAD, U_REFUSE);
      U_ENDU:   w = uw(1'b0, RS_CURNEXT, NM_FIRST, OP_UNLINK, J_GOTO, C_NEVER, U_SCH);
      U_REFUSE: w = uw(1'b0, RS_CUR, NM_HOLD, OP_REFUSE, J_GOTO, C_NEVER, U_FIN);
      U_NOFREE: w = uw(1'b0, RS_CUR, NM_HOLD, OP_NOFREE, J_GOTO, C_NEVER, U_FIN);
      U_FIN:    w = uw(1'b0, RS_CUR, NM_HOLD, OP_NONE, J_NEXT, C_NEVER, U_IDLE);
      U_RES:    w = uw(1'b0, RS_CUR, NM_HOLD, OP_RESULT, J_WAIT, C_OUT_BUSY, U_IDLE);
      default:  w = uw(1'b0, RS_CUR, NM_HOLD, OP_NONE, J_GOTO, C_NEVER, U_IDLE);
    endcase
    return w;
  endfunction

  // Entry point of each command's microroutine.
  function automatic upc_t disp_target(input logic [2:0] cmd);
    upc_t t;
    unique case (cmd)
      CMD_START:    t = U_START;
      CMD_SLEEP:    t = U_SLEEP;
      CMD_WAKEUP:   t = U_WAKE;
      CMD_SCHEDULE: t = U_SCH;
      CMD_END:      t = U_END;
      default:      t = U_REFUSE;
    endcase
    return t;
  endfunction

endpackage

### design/rrts_slot_table.sv
// ----------------------------------------------------------------------------
// Slot table
// Per-slot state, wait key and ring links with one read address, registered read
// data and one write port per field. Reads see a write to the same entry.
// ----------------------------------------------------------------------------
module rrts_slot_table import rrts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tbl_req_t req_i,
  output tbl_rsp_t rsp_o
);

  slot_st_e st_mem_q  [NUM_SLOTS];
  key_t     key_mem_q [NUM_SLOTS];
  slot_t    nx_mem_q  [NUM_SLOTS];
  slot_t    pv_mem_q  [NUM_SLOTS];

  slot_st_e st_rd_q;
  key_t     key_rd_q;
  slot_t    nx_rd_q;
  slot_t    pv_rd_q;

  logic [NUM_SLOTS-1:0] free_vec;
  slot_t                first_free;

  // Slot zero starts running and linked to itself; all links clear to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        st_mem_q[i] <= (i == 0) ? SS_RUN : SS_FREE;
        nx_mem_q[i] <= '0;
        pv_mem_q[i] <= '0;
      end
    end else begin
      if (req_i.st_we) begin
        st_mem_q[req_i.st_wa] <= req_i.st_wd;
      end
      if (req_i.nx_we) begin
        nx_mem_q[req_i.nx_wa] <= req_i.nx_wd;
      end
      if (req_i.pv_we) begin
        pv_mem_q[req_i.pv_wa] <= req_i.pv_wd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.key_we) begin
      key_mem_q[req_i.key_wa] <= req_i.key_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    st_rd_q  <= (req_i.st_we && req_i.st_wa == req_i.raddr) ? req_i.st_wd
                                                             : st_mem_q[req_i.raddr];
    key_rd_q <= (req_i.key_we && req_i.key_wa == req_i.raddr) ? req_i.key_wd
                                                               : key_mem_q[req_i.raddr];
    nx_rd_q  <= (req_i.nx_we && req_i.nx_wa == req_i.raddr) ? req_i.nx_wd
                                                             : nx_mem_q[req_i.raddr];
    pv_rd_q  <= (req_i.pv_we && req_i.pv_wa == req_i.raddr) ? req_i.pv_wd
                                                             : pv_mem_q[req_i.raddr];
  end

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      free_vec[i] = (st_mem_q[i] == SS_FREE);
    end
  end

  // Lowest numbered free slot.
  always_comb begin
    first_free = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        first_free = SLOT_W'(i);
      end
    end
  end

  assign rsp_o.st         = st_rd_q;
  assign rsp_o.key        = key_rd_q;
  assign rsp_o.nx         = nx_rd_q;
  assign rsp_o.pv         = pv_rd_q;
  assign rsp_o.any_free   = |free_vec;
  assign rsp_o.first_free = first_free;

endmodule

### design/round_robin_thread_scheduler.sv
// ----------------------------------------------------------------------------
// Round-robin thread scheduler
// Microcoded sequencer over a slot table: start, sleep, wakeup, schedule and
// end commands on a ring of thread slots, one result item per command.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o | command_i, chan_key_i
//  out     | output    | out_valid_o/out_ready_i | status_o, running_slot_o,
//          |           |                         | running_valid_o,
//          |           |                         | started_slot_o, woken_count_o
//
// Start, sleep and refused commands need no walk; wakeup, schedule and end
// also walk the ring, visiting up to NUM_SLOTS slots, one per cycle through
// the table's single read port. Reset puts slot zero running directly in the
// table's flip-flops; there is no clearing pass. A finished result waits in
// the output register while the next item is accepted; the sequencer holds
// in its result step only while that register is still full.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler import rrts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] chan_key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  running_slot_o,
  output logic        running_valid_o,
  output logic [3:0]  started_slot_o,
  output logic [3:0]  woken_count_o
);

  ucw_t     uw;
  tbl_req_t req;
  tbl_rsp_t rsp;

  upc_t upc_q, upc_d;
  slot_t cur_q;
  logic  live_q;
  logic  out_valid_q;

  logic [2:0] cmd_q;
  key_t       key_q;
  slot_st_e   curst_q;
  slot_t      curnext_q;
  slot_t      curprev_q;
  slot_t      node_q;
  slot_t      cnt_q;
  slot_t      free_q;
  slot_t      hit_q;
  logic [1:0] res_status_q;
  slot_t      started_q;
  logic [3:0] woken_q;

  logic [1:0] out_status_q;
  logic [3:0] out_slot_q;
  logic       out_run_q;
  logic [3:0] out_started_q;
  logic [3:0] out_woken_q;

  logic  in_fire;
  logic  out_busy;
  logic  cur_running;
  logic  walk_more;
  logic  hit;
  logic  wake_hit;
  logic  cond_true;
  slot_t raddr;

  assign uw = ucode_rom(upc_q);

  rrts_slot_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign in_ready_o  = uw.accept;
  assign in_fire     = in_valid_i && uw.accept;
  assign out_busy    = out_valid_q && !out_ready_i;
  assign cur_running = live_q && (curst_q == SS_RUN);
  // The walk stops after the current slot or after NUM_SLOTS visits.
  assign walk_more   = (node_q != cur_q) && (cnt_q != SLOT_W'(NUM_SLOTS - 1));
  assign hit         = (rsp.st == SS_READY);
  assign wake_hit    = (rsp.st == SS_SLEEP) && (rsp.key == key_q);

  always_comb begin
    unique case (uw.cond)
      C_NEVER:    cond_true = 1'b0;
      C_NO_IN:    cond_true = !in_valid_i;
      C_NOT_LIVE: cond_true = !live_q;
      C_NO_FREE:  cond_true = !rsp.any_free;
      C_NOT_RUN:  cond_true = !cur_running;
      C_END_BAD:  cond_true = !cur_running || (curnext_q == cur_q);
      C_HIT:      cond_true = hit;
      C_OUT_BUSY: cond_true = out_busy;
      default:    cond_true = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uw.jmp)
      J_NEXT:  upc_d = upc_q + 1'b1;
      J_GOTO:  upc_d = uw.tgt;
      J_IF:    upc_d = cond_true ? uw.tgt : upc_q + 1'b1;
      J_WAIT:  upc_d = cond_true ? upc_q : uw.tgt;
      J_LOOP:  upc_d = cond_true ? uw.tgt : (walk_more ? upc_q : upc_q + 1'b1);
      J_DISP:  upc_d = disp_target(cmd_q);
      default: upc_d = U_IDLE;
    endcase
  end

  always_comb begin
    unique case (uw.rsel)
      RS_CUR:     raddr = cur_q;
      RS_NEXT:    raddr = rsp.nx;
      RS_CURNEXT: raddr = curnext_q;
      default:    raddr = cur_q;
    endcase
  end

  // Table writes for each step.
  always_comb begin
    req        = '0;
    req.raddr  = raddr;
    req.st_wd  = SS_FREE;
    case (uw.op)
      OP_START_A: begin
        req.st_we = 1'b1;
        req.st_wa = free_q;
        req.st_wd = SS_READY;
        req.nx_we = 1'b1;
        req.nx_wa = free_q;
        req.nx_wd = curnext_q;
        req.pv_we = 1'b1;
        req.pv_wa = free_q;
        req.pv_wd = cur_q;
      end
      OP_START_B: begin
        req.nx_we = 1'b1;
        req.nx_wa = cur_q;
        req.nx_wd = free_q;
        req.pv_we = 1'b1;
        req.pv_wa = curnext_q;
        req.pv_wd = free_q;
      end
      OP_SLEEP: begin
        req.st_we  = 1'b1;
        req.st_wa  = cur_q;
        req.st_wd  = SS_SLEEP;
        req.key_we = 1'b1;
        req.key_wa = cur_q;
        req.key_wd = key_q;
      end
      OP_WAKE: begin
        req.st_we = wake_hit;
        req.st_wa = node_q;
        req.st_wd = SS_READY;
      end
      OP_DEMOTE: begin
        req.st_we = (curst_q == SS_RUN);
        req.st_wa = cur_q;
        req.st_wd = SS_READY;
      end
      OP_PROMOTE: begin
        req.st_we = 1'b1;
        req.st_wa = hit_q;
        req.st_wd = SS_RUN;
      end
      OP_UNLINK: begin
        req.nx_we = 1'b1;
        req.nx_wa = curprev_q;
        req.nx_wd = curnext_q;
        req.pv_we = 1'b1;
        req.pv_wa = curnext_q;
        req.pv_wd = curprev_q;
        req.st_we = 1'b1;
        req.st_wa = cur_q;
        req.st_wd = SS_FREE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_IDLE;
      cur_q       <= '0;
      live_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (uw.op == OP_PROMOTE) begin
        cur_q  <= hit_q;
        live_q <= 1'b1;
      end else if (uw.op == OP_UNLINK) begin
        live_q <= 1'b0;
      end
      if (uw.op == OP_RESULT && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (uw.node)
      NM_FIRST: begin
        node_q <= raddr;
        cnt_q  <= '0;
      end
      NM_STEP: begin
        node_q <= raddr;
        cnt_q  <= cnt_q + 1'b1;
      end
      default: begin
      end
    endcase

    case (uw.op)
      OP_ACCEPT: begin
        if (in_fire) begin
          cmd_q        <= command_i;
          key_q        <= KEY_BITS'(chan_key_i);
          res_status_q <= STAT_OK;
          started_q    <= '0;
          woken_q      <= '0;
        end
      end
      OP_LATCH: begin
        curst_q   <= rsp.st;
        curnext_q <= rsp.nx;
        curprev_q <= rsp.pv;
      end
      OP_FIND:    free_q <= rsp.first_free;
      OP_START_A: started_q <= free_q;
      OP_WAKE: begin
        if (wake_hit && woken_q != WOKEN_MAX) begin
          woken_q <= woken_q + 1'b1;
        end
      end
      OP_SCAN: begin
        if (hit) begin
          hit_q <= node_q;
        end
      end
      OP_FAIL:   res_status_q <= (curst_q == SS_RUN) ? STAT_OK : STAT_NORUN;
      OP_UNLINK: curst_q <= SS_FREE;
      OP_REFUSE: res_status_q <= STAT_REFUSED;
      OP_NOFREE: res_status_q <= STAT_NOFREE;
      OP_RESULT: begin
        if (!out_busy) begin
          out_status_q  <= res_status_q;
          out_slot_q    <= 4'(cur_q);
          // The finish step read the current slot's entry.
          out_run_q     <= (rsp.st == SS_RUN);
          out_started_q <= 4'(started_q);
          out_woken_q   <= woken_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign running_slot_o  = out_slot_q;
  assign running_valid_o = out_run_q;
  assign started_slot_o  = out_started_q;
  assign woken_count_o   = out_woken_q;

endmodule

### design/rrts_checker.sv
// ----------------------------------------------------------------------------
// Scheduler port checker
// Watches the top level's ports; flags impossible result items and back-to-back accepts.
// ----------------------------------------------------------------------------
module rrts_checker import rrts_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [3:0]  running_slot_o,
  input logic        running_valid_o,
  input logic [3:0]  started_slot_o,
  input logic [3:0]  woken_count_o
);

  // A stalled result item holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(running_slot_o) && $stable(started_slot_o) && $stable(woken_count_o))
    else $error("result item changed while stalled");

  // An accepted item keeps the input closed in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // Woken slots are only reported with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && woken_count_o != 4'd0 |-> status_o == STAT_OK)
    else $error("woken count with failing status");

  // A started slot is only reported with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && started_slot_o != 4'd0 |-> status_o == STAT_OK)
    else $error("started slot with failing status");

  // No runnable thread means the current slot is not running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_NORUN |-> !running_valid_o)
    else $error("running slot reported with no runnable thread");

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (.*);

### bench/round_robin_thread_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Round-robin thread scheduler testbench
// Sends command items to the scheduler over its input channel and checks every
// result item against a cycle-free model of the slot ring kept in the bench.
// A short directed table covers the corner cases. Random command sequences
// then fill the table, put threads to sleep, wake them and end them, under
// several idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_tb;
  import rrts_pkg::*;

  localparam logic [2:0] CMD_BAD_LO     = 3'd5;
  localparam logic [2:0] CMD_BAD_HI     = 3'd7;
  localparam int         RANDOM_ITEMS   = 1270;
  localparam int         PHASES         = 10;
  localparam int         LONG_HOLD      = 300;
  localparam int         MAX_GAP        = 40;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         LINGER         = 4 * NUM_SLOTS + 16;
  localparam int         MAX_PRINTED    = 50;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot;
    logic       live;
    logic [3:0] started;
    logic [3:0] woken;
  } sched_result_t;

  typedef struct {
    logic [2:0]    cmd;
    key_t          key;
    int            reps;
    bit            typed;
    sched_result_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i   = 3'd0;
  logic [31:0] chan_key_i  = 32'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  running_slot_o;
  logic        running_valid_o;
  logic [3:0]  started_slot_o;
  logic [3:0]  woken_count_o;

  round_robin_thread_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .chan_key_i      (chan_key_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .running_slot_o  (running_slot_o),
    .running_valid_o (running_valid_o),
    .started_slot_o  (started_slot_o),
    .woken_count_o   (woken_count_o)
  );

  // Bench copy of the slot table.
  slot_st_e ring_state [NUM_SLOTS];
  key_t     ring_key   [NUM_SLOTS];
  slot_t    ring_next  [NUM_SLOTS];
  slot_t    ring_prev  [NUM_SLOTS];
  slot_t    ring_cur;
  logic     ring_live;

  sched_result_t pending_results[$];
  dir_row_t      dir_table [19];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int fail_count     = 0;
  int quiet_cycles   = 0;
  int largest_woken  = 0;
  int status_tally [4];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Moves the current slot to the first ready slot after it in the ring.
  function automatic logic switch_to_ready();
    slot_t old;
    slot_t node;
    old  = ring_cur;
    node = ring_next[old];
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (ring_state[node] == SS_READY) begin
        if (ring_state[old] == SS_RUN) ring_state[old] = SS_READY;
        ring_cur         = node;
        ring_live        = 1'b1;
        ring_state[node] = SS_RUN;
        break;
      end
      if (node == old) break;
      node = ring_next[node];
    end
    return ring_state[ring_cur] == SS_RUN;
  endfunction

  function automatic sched_result_t apply_command(input logic [2:0] cmd, input key_t key);
    sched_result_t r;
    slot_t         cur;
    slot_t         node;
    logic          cur_running;
    int            free_slot;
    r           = '0;
    cur         = ring_cur;
    cur_running = ring_live && ring_state[cur] == SS_RUN;
    case (cmd)
      CMD_START: begin
        free_slot = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (free_slot < 0 && ring_state[i] == SS_FREE) free_slot = i;
        end
        if (!ring_live) begin
          r.status = STAT_REFUSED;
        end else if (free_slot < 0) begin
          r.status = STAT_NOFREE;
        end else begin
          node                  = ring_next[cur];
          ring_state[free_slot] = SS_READY;
          ring_key[free_slot]   = '0;
          ring_prev[free_slot]  = cur;
          ring_next[free_slot]  = node;
          ring_prev[node]       = slot_t'(free_slot);
          ring_next[cur]        = slot_t'(free_slot);
          r.started             = 4'(free_slot);
        end
      end
      CMD_SLEEP: begin
        if (!cur_running) begin
          r.status = STAT_REFUSED;
        end else begin
          ring_state[cur] = SS_SLEEP;
          ring_key[cur]   = key;
        end
      end
      CMD_WAKEUP: begin
        node = ring_next[cur];
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (ring_state[node] == SS_SLEEP && ring_key[node] == key) begin
            ring_state[node] = SS_READY;
            ring_key[node]   = '0;
            if (r.woken != WOKEN_MAX) r.woken = r.woken + 4'd1;
          end
          if (node == cur) break;
          node = ring_next[node];
        end
      end
      CMD_SCHEDULE: begin
        r.status = switch_to_ready() ? STAT_OK : STAT_NORUN;
      end
      CMD_END: begin
        if (!cur_running || ring_next[cur] == cur) begin
          r.status = STAT_REFUSED;
        end else begin
          ring_next[ring_prev[cur]] = ring_next[cur];
          ring_prev[ring_next[cur]] = ring_prev[cur];
          ring_state[cur]           = SS_FREE;
          ring_key[cur]             = '0;
          ring_live                 = 1'b0;
          r.status = switch_to_ready() ? STAT_OK : STAT_NORUN;
        end
      end
      default: r.status = STAT_REFUSED;
    endcase
    r.slot = 4'(ring_cur);
    r.live = ring_state[ring_cur] == SS_RUN;
    return r;
  endfunction

  function automatic dir_row_t plain_row(input logic [2:0] cmd, input key_t key, input int reps);
    dir_row_t row;
    row.cmd   = cmd;
    row.key   = key;
    row.reps  = reps;
    row.typed = 1'b0;
    row.res   = '0;
    return row;
  endfunction

  function automatic dir_row_t typed_row(input logic [2:0] cmd, input key_t key,
                                         input logic [1:0] status, input logic [3:0] slot,
                                         input logic live, input logic [3:0] started);
    dir_row_t row;
    row       = plain_row(cmd, key, 1);
    row.typed = 1'b1;
    row.res   = '{status: status, slot: slot, live: live, started: started, woken: 4'd0};
    return row;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= MAX_PRINTED) begin
      $display("%0t: result %0d %s: got %0h, expected %0h", $time, results_seen, what, got,
               want);
    end
  endtask

  // Offers one command item and records its expected result once accepted.
  task automatic send_command(input logic [2:0] cmd, input key_t key, input bit typed,
                              input sched_result_t typed_res);
    int            gap;
    sched_result_t res;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    chan_key_i <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res = apply_command(cmd, key);
    pending_results.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic send(input logic [2:0] cmd, input key_t key);
    send_command(cmd, key, 1'b0, '0);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Sleep keys come from a small set so that wakeups find their sleepers.
  function automatic key_t pool_key(input int idx);
    case (idx)
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h5A5A_A5A5;
    endcase
  endfunction

  task automatic random_command();
    int   pick;
    key_t key;
    pick = $urandom_range(99);
    key  = $urandom;
    if (pick < 18) begin
      send(CMD_START, key);
    end else if (pick < 38) begin
      send(CMD_SLEEP, pool_key($urandom_range(4)));
    end else if (pick < 58) begin
      send(CMD_WAKEUP, ($urandom_range(4) != 0) ? pool_key($urandom_range(4)) : key);
    end else if (pick < 83) begin
      send(CMD_SCHEDULE, key);
    end else if (pick < 97) begin
      send(CMD_END, key);
    end else begin
      send(3'($urandom_range(CMD_BAD_HI, CMD_BAD_LO)), key);
    end
  endtask

  task automatic random_sequence();
    int   pick;
    key_t key;
    pick = $urandom_range(99);
    key  = pool_key($urandom_range(4));
    if (pick < 65) begin
      random_command();
    end else if (pick < 77) begin
      repeat ($urandom_range(NUM_SLOTS, 2)) send(CMD_START, $urandom);
    end else if (pick < 85) begin
      // Wake everybody, fill the table, then put every slot to sleep on one
      // key so that the final wakeup sees the whole ring.
      for (int i = 0; i < 5; i++) send(CMD_WAKEUP, pool_key(i));
      send(CMD_SCHEDULE, $urandom);
      repeat (NUM_SLOTS) send(CMD_START, $urandom);
      repeat (NUM_SLOTS + 1) begin
        send(CMD_SLEEP, key);
        send(CMD_SCHEDULE, $urandom);
      end
      send(CMD_WAKEUP, key);
    end else begin
      repeat ($urandom_range(8, 2)) begin
        send(CMD_SCHEDULE, $urandom);
        send(CMD_END, $urandom);
      end
    end
  endtask

  // Result side: checks accepted results and drives the ready with stalls.
  always @(posedge clk_i) begin
    sched_result_t got;
    sched_result_t want;
    if (out_valid_o && out_ready_i) begin
      got = '{status: status_o, slot: running_slot_o, live: running_valid_o,
              started: started_slot_o, woken: woken_count_o};
      results_seen++;
      status_tally[got.status]++;
      if (int'(got.woken) > largest_woken) largest_woken = int'(got.woken);
      if (pending_results.size() == 0) begin
        report_mismatch("arrived with nothing pending", 32'(got), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          report_mismatch("status", 32'(got.status), 32'(want.status));
        end
        if (got.slot !== want.slot) begin
          report_mismatch("running_slot", 32'(got.slot), 32'(want.slot));
        end
        if (got.live !== want.live) begin
          report_mismatch("running_valid", 32'(got.live), 32'(want.live));
        end
        if (got.started !== want.started) begin
          report_mismatch("started_slot", 32'(got.started), 32'(want.started));
        end
        if (got.woken !== want.woken) begin
          report_mismatch("woken_count", 32'(got.woken), 32'(want.woken));
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= LONG_HOLD;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("round_robin_thread_scheduler verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int dir_items;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ring_state[i] = SS_FREE;
      ring_key[i]   = '0;
      ring_next[i]  = '0;
      ring_prev[i]  = '0;
    end
    ring_state[0] = SS_RUN;
    ring_cur      = '0;
    ring_live     = 1'b1;
    for (int i = 0; i < 4; i++) status_tally[i] = 0;

    dir_table = '{
      typed_row(CMD_SCHEDULE, 32'h0000_0000, STAT_OK, 4'd0, 1'b1, 4'd0),
      // A lone slot cannot end itself.
      typed_row(CMD_END, 32'h0000_0000, STAT_REFUSED, 4'd0, 1'b1, 4'd0),
      typed_row(CMD_BAD_LO, 32'hFFFF_FFFF, STAT_REFUSED, 4'd0, 1'b1, 4'd0),
      typed_row(CMD_BAD_HI, 32'h0000_0000, STAT_REFUSED, 4'd0, 1'b1, 4'd0),
      typed_row(CMD_START, 32'hFFFF_FFFF, STAT_OK, 4'd0, 1'b1, 4'd1),
      typed_row(CMD_SLEEP, 32'hFFFF_FFFF, STAT_OK, 4'd0, 1'b0, 4'd0),
      typed_row(CMD_SLEEP, 32'h0000_0000, STAT_REFUSED, 4'd0, 1'b0, 4'd0),
      typed_row(CMD_END, 32'h0000_0000, STAT_REFUSED, 4'd0, 1'b0, 4'd0),
      plain_row(CMD_SCHEDULE, 32'h0000_0000, 1),
      // Ending slot one leaves only a sleeper behind: the slot is freed anyway.
      typed_row(CMD_END, 32'h0000_0000, STAT_NORUN, 4'd1, 1'b0, 4'd0),
      typed_row(CMD_START, 32'h0000_0000, STAT_REFUSED, 4'd1, 1'b0, 4'd0),
      plain_row(CMD_WAKEUP, 32'h0000_0000, 1),
      plain_row(CMD_WAKEUP, 32'hFFFF_FFFF, 1),
      plain_row(CMD_SCHEDULE, 32'h0000_0000, 1),
      plain_row(CMD_START, 32'h0000_0000, NUM_SLOTS - 1),
      typed_row(CMD_START, 32'h0000_0000, STAT_NOFREE, 4'd0, 1'b1, 4'd0),
      plain_row(CMD_WAKEUP, 32'h5A5A_A5A5, 1),
      plain_row(CMD_SCHEDULE, 32'hFFFF_FFFF, 1),
      plain_row(CMD_END, 32'h0000_0000, 1)
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 10;
    recv_stall_pct = 10;
    foreach (dir_table[r]) begin
      repeat (dir_table[r].reps) begin
        send_command(dir_table[r].cmd, dir_table[r].key, dir_table[r].typed, dir_table[r].res);
      end
    end
    drain_results();
    dir_items = items_sent;

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct  = 10;
          recv_stall_pct = 10;
        end
      endcase
      // Once, the receiver holds off for a long stretch while items keep coming.
      if (phase == 0) hold_req <= hold_req + 1;
      while (items_sent < dir_items + (phase + 1) * RANDOM_ITEMS / PHASES) random_sequence();
      drain_results();
    end

    repeat (LINGER) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("results still pending", pending_results.size(), 32'd0);
    end

    $display("Summary: %0d command items sent, %0d result items checked, %0d mismatches.",
             items_sent, results_seen, fail_count);
    $display("Summary: ok %0d, no free slot %0d, nothing runnable %0d, refused %0d; %s %0d.",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             "largest wakeup count", largest_woken);
    if (fail_count == 0) begin
      $display("round_robin_thread_scheduler verification clean");
    end else begin
      $display("round_robin_thread_scheduler verification failed");
    end
    $finish;
  end

endmodule
